[src/int_to_decimal_ascii_top_assert.svh]
// assertion macros used by the int_to_decimal_ascii top level
`ifndef INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ITDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itda: same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define ITDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itda: next-cycle check failed");

`endif

[src/itda_pkg.sv]
// shared types and constants for the decimal ascii converter
`default_nettype none

package itda_pkg;

  // longest text the block will produce
  localparam int MAX_CHARS  = 16;
  localparam int VAL_W      = 32;
  localparam int LEN_W      = 5;
  localparam int CHAR_W     = 8;
  // decimal digits of a 32-bit magnitude
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IW     = $clog2(NUM_DIGITS);
  localparam int STEP_W     = $clog2(VAL_W);
  // counter width for lengths up to MAX_CHARS plus a sign
  localparam int CNT_W      = ($clog2(MAX_CHARS + 2) > LEN_W) ? $clog2(MAX_CHARS + 2) : LEN_W;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        size_limit;
    logic [LEN_W-1:0]        min_digits;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic              overflow;
    logic [LEN_W-1:0]  text_length;
  } out_item_t;

  // bcd digits, index 0 is the least significant
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // formatting request handed to the character emitter
  typedef struct packed {
    logic             negative;
    logic [LEN_W-1:0] size_limit;
    logic [LEN_W-1:0] min_digits;
  } emit_req_t;

endpackage

`default_nettype wire

[src/itda_bcd_conv.sv]
// bit-serial binary to bcd converter (shift and add-3)
`default_nettype none

module itda_bcd_conv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itda_pkg::VAL_W-1:0]  mag_i,
  output itda_pkg::bcd_t              bcd_o,
  output logic                        done_o
);
  import itda_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0]  bin_q, bin_d;
  bcd_t              bcd_q, bcd_d;
  bcd_t              bcd_adj;
  logic [4*NUM_DIGITS-1:0] adj_flat;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign adj_flat = bcd_adj;

  // one magnitude bit enters the bcd register per cycle, msb first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj_flat[4*NUM_DIGITS-2:0], bin_q[VAL_W-1]};
      bin_d = {bin_q[VAL_W-2:0], 1'b0};
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(VAL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // data shift registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[src/itda_emit.sv]
// character emitter: sign, zero padding and digits (or one NUL on overflow), one per cycle unless the output stalls
`default_nettype none

module itda_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  itda_pkg::emit_req_t  req_i,
  input  itda_pkg::bcd_t       bcd_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output itda_pkg::out_item_t  out_data_o,
  output logic                 done_o
);
  import itda_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic       err_q, err_d;
  logic       minus_q, minus_d;
  logic       done_q, done_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] pos_q, pos_d;

  logic [CNT_W-1:0] lim_ext, lim, pad, ndig, ndigits, total;
  logic             ovf;
  logic             slot_free;
  logic [3:0]       digit;

  // text geometry from the finished bcd digits
  always_comb begin
    lim_ext = CNT_W'(req_i.size_limit);
    lim     = (lim_ext > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : lim_ext;
    pad     = CNT_W'(req_i.min_digits);
    if (pad > lim) begin
      pad = lim;
    end
    ndig = CNT_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_i[i] != 4'd0) begin
        ndig = CNT_W'(i + 1);
      end
    end
    ndigits = (pad > ndig) ? pad : ndig;
    total   = ndigits + CNT_W'(req_i.negative);
    ovf     = (lim == '0) || (ndig > lim) || (total > lim);
  end

  // digit at the current position, zero above the bcd width
  assign digit = (pos_q < CNT_W'(NUM_DIGITS)) ? bcd_i[pos_q[DIG_IW-1:0]] : 4'd0;

  assign slot_free = !out_valid_q || !out_stall_i;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    minus_d     = minus_q;
    total_d     = total_q;
    pos_d       = pos_q;
    done_d      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EMIT;
          err_d   = ovf;
          minus_d = req_i.negative;
          total_d = ovf ? '0 : total;
          pos_d   = ndigits - CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_data_d.text_length = total_q[LEN_W-1:0];
          out_data_d.overflow    = err_q;
          if (err_q) begin
            out_data_d.character = CH_NUL;
            out_data_d.is_last   = 1'b1;
            state_d              = S_IDLE;
            done_d               = 1'b1;
          end else if (minus_q) begin
            out_data_d.character = CH_MINUS;
            out_data_d.is_last   = 1'b0;
            minus_d              = 1'b0;
          end else begin
            out_data_d.character = CH_ZERO + {4'd0, digit};
            out_data_d.is_last   = (pos_q == '0);
            if (pos_q == '0) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              pos_d = pos_q - CNT_W'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= 1'b0;
      minus_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      minus_q     <= minus_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

[src/int_to_decimal_ascii_top.sv]
// top level: signed 32-bit integer to decimal ascii text
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | in_item_t: value, size_limit, min_digits
//  out     | output    | out_valid_o/out_stall_i | out_item_t: one character per transaction
//
// one item at a time: shift-and-add-3 bcd conversion, then one character per
// cycle from the emitter while the output is not stalled; an error result is a
// single NUL character. in_stall_o stays high from an accepted transaction until
// the emitter's done flag, registered along with the last character, is taken
// into the busy register; output stalls add to this.
// reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none
`include "int_to_decimal_ascii_top_assert.svh"

module int_to_decimal_ascii_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  itda_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output itda_pkg::out_item_t  out_data_o
);
  import itda_pkg::*;

  logic             in_accept;
  logic             item_busy_q, item_busy_d;
  logic [VAL_W-1:0] raw;
  logic [VAL_W-1:0] mag;
  emit_req_t        req_q;
  bcd_t             bcd;
  logic             conv_done;
  logic             emit_done;
  logic             ovf_shape_ok;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = item_busy_q;

  // magnitude of the signed value; the most negative value maps to 2^31
  assign raw = in_data_i.value;
  assign mag = raw[VAL_W-1] ? (~raw + VAL_W'(1)) : raw;

  // busy from acceptance until the emitter has loaded the last character
  always_comb begin
    item_busy_d = item_busy_q;
    if (in_accept) begin
      item_busy_d = 1'b1;
    end else if (emit_done) begin
      item_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_busy_q <= 1'b0;
    end else begin
      item_busy_q <= item_busy_d;
    end
  end

  // formatting request captured with the transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.negative   <= raw[VAL_W-1];
      req_q.size_limit <= in_data_i.size_limit;
      req_q.min_digits <= in_data_i.min_digits;
    end
  end

  itda_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .mag_i   (mag),
    .bcd_o   (bcd),
    .done_o  (conv_done)
  );

  itda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (conv_done),
    .req_i       (req_q),
    .bcd_i       (bcd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .done_o      (emit_done)
  );

  // shape of an error result
  assign ovf_shape_ok = out_data_o.is_last && (out_data_o.text_length == '0) &&
                        (out_data_o.character == CH_NUL);

  // checks
  `ITDA_ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, in_accept, in_stall_o)
  `ITDA_ASSERT_IMP(a_conv_in_item, clk_i, rst_ni, conv_done, item_busy_q)
  `ITDA_ASSERT_IMP(a_ovf_alone, clk_i, rst_ni, out_valid_o && out_data_o.overflow, ovf_shape_ok)
  `ITDA_ASSERT_IMP(a_len_nonzero, clk_i, rst_ni, out_valid_o && !out_data_o.overflow, out_data_o.text_length != '0)

endmodule

`default_nettype wire

[verif/int_to_decimal_ascii_top_test.sv]
// testbench for the signed integer to decimal ascii converter with its own text predictor
`timescale 1ns / 100ps

module int_to_decimal_ascii_top_test;
  import itda_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_PRINTED    = 50;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  // expected characters, oldest first
  out_item_t expected_chars [$];
  out_item_t want_char;

  int  mismatch_count;
  int  values_sent;
  int  negatives_sent;
  int  chars_seen;
  int  overflows_seen;
  bit  idle_enable;
  int  hold_request;

  int_to_decimal_ascii_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // mismatch report, printing capped to keep the log short
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // expected text of one value: sign, zero padding, digits; or one overflow result
  function automatic void predict_text(input in_item_t item);
    logic [31:0] mag;
    logic [3:0]  digs [16];
    int unsigned ndig;
    int unsigned lim;
    int unsigned pad;
    int unsigned nshow;
    int unsigned total;
    int unsigned pos;
    logic        neg;
    out_item_t   r;
    neg = item.value[31];
    mag = neg ? (32'd0 - item.value) : item.value;
    lim = 32'(item.size_limit);
    if (lim > MAX_CHARS) lim = MAX_CHARS;
    pad = 32'(item.min_digits);
    if (pad > lim) pad = lim;
    ndig = 0;
    do begin
      digs[ndig] = 4'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    nshow = (pad > ndig) ? pad : ndig;
    total = nshow + 32'(neg);
    if (lim == 0 || ndig > lim || total > lim) begin
      r.character   = CH_NUL;
      r.is_last     = 1'b1;
      r.overflow    = 1'b1;
      r.text_length = '0;
      expected_chars.push_back(r);
      return;
    end
    for (pos = 0; pos < total; pos++) begin
      if (neg && pos == 0) r.character = CH_MINUS;
      else if (pos < total - ndig) r.character = CH_ZERO;
      else r.character = CH_ZERO + {4'd0, digs[total - 1 - pos]};
      r.is_last     = (pos == total - 1);
      r.overflow    = 1'b0;
      r.text_length = total[LEN_W-1:0];
      expected_chars.push_back(r);
    end
  endfunction

  // random value: full range, small, around powers of ten, extremes, shifted magnitudes; random sign
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    logic [31:0] p;
    int          k;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9);
      2: begin
        k = $urandom_range(0, 9);
        p = 32'd1;
        repeat (k) p = p * 32'd10;
        v = p - 32'd1 + $urandom_range(0, 2);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h8000_0001;
          default: v = 32'h0;
        endcase
      end
      4: v = $urandom_range(0, 999);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       r;
    it.value = rand_value();
    r = $urandom_range(0, 99);
    if (r < 5) it.size_limit = '0;
    else if (r < 20) it.size_limit = LEN_W'($urandom_range(17, 31));
    else if (r < 50) it.size_limit = LEN_W'($urandom_range(1, 10));
    else it.size_limit = LEN_W'($urandom_range(11, 16));
    r = $urandom_range(0, 99);
    if (r < 50) it.min_digits = '0;
    else if (r < 80) it.min_digits = LEN_W'($urandom_range(1, 12));
    else it.min_digits = LEN_W'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic in_item_t make_item(input logic [31:0] v, input int lim, input int pad);
    in_item_t it;
    it.value      = v;
    it.size_limit = lim[LEN_W-1:0];
    it.min_digits = pad[LEN_W-1:0];
    return it;
  endfunction

  // one input transaction; returns at the falling edge after acceptance
  task automatic send_value(input in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_text(item);
    values_sent++;
    if (item.value[31]) negatives_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait until every expected character has arrived
  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // extremes, padding, saturation and overflow cases
  task automatic test_directed();
    send_value(make_item(32'd0, 1, 0));
    send_value(make_item(32'd0, 16, 0));
    send_value(make_item(32'd1, 11, 0));
    send_value(make_item(32'hffff_ffff, 2, 0));
    send_value(make_item(32'hffff_ffff, 1, 0));
    send_value(make_item(32'd10, 1, 0));
    send_value(make_item(32'd9, 1, 1));
    send_value(make_item(32'h7fff_ffff, 10, 0));
    send_value(make_item(32'h7fff_ffff, 9, 0));
    send_value(make_item(32'h8000_0000, 11, 0));
    send_value(make_item(32'h8000_0000, 10, 0));
    send_value(make_item(32'd5, 0, 0));
    send_value(make_item(32'd5, 31, 31));
    send_value(make_item(32'hffff_fffb, 31, 31));
    send_value(make_item(32'hffff_fffb, 31, 15));
    send_value(make_item(32'd7, 4, 9));
    send_value(make_item(32'hffff_ffd6, 5, 4));
    send_value(make_item(32'hffff_ffd6, 4, 4));
    send_value(make_item(32'd1234, 16, 16));
    send_value(make_item(32'd0, 16, 31));
    send_value(make_item(32'h8000_0001, 20, 12));
    wait_results_drained();
  endtask

  // random values, limits and padding with random idling on both sides
  task automatic test_random_mix();
    repeat (200) send_value(rand_item());
    wait_results_drained();
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (40) send_value(rand_item());
    wait_results_drained();
    idle_enable = 1'b1;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    hold_request = LONG_HOLD;
    repeat (12) send_value(rand_item());
    wait_results_drained();
  endtask

  // sender pauses until all characters are out, several times
  task automatic test_drain_pause();
    repeat (6) begin
      repeat ($urandom_range(1, 4)) send_value(rand_item());
      wait_results_drained();
    end
  endtask

  // output stall: random gaps, or one long hold-off when asked
  initial begin : out_stall_gen
    int stall_left;
    int free_left;
    stall_left  = 0;
    free_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        out_stall_i = 1'b1;
        repeat (hold_request) @(negedge clk_i);
        hold_request = 0;
        out_stall_i  = 1'b0;
      end else if (!idle_enable) begin
        out_stall_i = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall_i = 1'b0;
        free_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left  = pick_gap();
        free_left   = $urandom_range(1, 12);
      end
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (out_data_o.overflow === 1'b1) overflows_seen++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character %h with nothing expected",
                                  out_data_o.character));
      end else begin
        want_char = expected_chars.pop_front();
        if (out_data_o.character !== want_char.character)
          report_mismatch($sformatf("character got %h want %h",
                                    out_data_o.character, want_char.character));
        if (out_data_o.is_last !== want_char.is_last)
          report_mismatch($sformatf("is_last got %b want %b",
                                    out_data_o.is_last, want_char.is_last));
        if (out_data_o.overflow !== want_char.overflow)
          report_mismatch($sformatf("overflow got %b want %b",
                                    out_data_o.overflow, want_char.overflow));
        if (out_data_o.text_length !== want_char.text_length)
          report_mismatch($sformatf("text_length got %0d want %0d",
                                    out_data_o.text_length, want_char.text_length));
      end
    end
  end

  // watchdog: too many cycles without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    idle_enable    = 1'b1;
    hold_request   = 0;
    mismatch_count = 0;
    values_sent    = 0;
    negatives_sent = 0;
    chars_seen     = 0;
    overflows_seen = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix();
    test_back_to_back();
    test_output_hold();
    test_drain_pause();

    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
    $display("converted %0d values (%0d negative), checked %0d characters, %0d overflow",
             values_sent, negatives_sent, chars_seen, overflows_seen);
    $display("covered saturated limits, padding, back-to-back traffic and long hold-offs");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/itda_pkg.sv
src/itda_bcd_conv.sv
src/itda_emit.sv
src/int_to_decimal_ascii_top.sv
verif/int_to_decimal_ascii_top_test.sv
